// ----- rtl/fcca_pkg.sv -----
// Shared types, codes and constants of the cluster chain allocator.
package fcca_pkg;

  localparam int MAX_CLUSTERS_DEF = 8192;

  localparam logic [13:0] CLUSTER_COUNT_RST = 14'd640;
  localparam logic [12:0] TABLE_CLUSTER_RST = 13'd1;
  localparam logic [12:0] ROOT_CLUSTER_RST  = 13'd2;

  localparam logic [15:0] END_MARK  = 16'hFFFF;
  localparam logic [15:0] FREE_MARK = 16'h0000;

  typedef enum logic [2:0] {
    OP_ALLOC  = 3'd0,
    OP_EXTEND = 3'd1,
    OP_FREE   = 3'd2,
    OP_READ   = 3'd3,
    OP_WRITE  = 3'd4,
    OP_COUNT  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_RANGE  = 2'd2,
    ST_BROKEN = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_CLUSTER_COUNT = 2'd0,
    CFG_TABLE_CLUSTER = 2'd1,
    CFG_ROOT_CLUSTER  = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    MEM_IDLE,
    MEM_CLEAR,
    MEM_SCAN,
    MEM_RD_IDX,
    MEM_WR_IDX_VAL,
    MEM_WR_IDX_FOUND,
    MEM_WR_FOUND_END,
    MEM_RD_CUR,
    MEM_WR_CUR_ZERO
  } mem_act_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [12:0] index;
    logic [15:0] value;
  } fcca_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [12:0] cluster;
    logic [15:0] entry;
    logic [13:0] free_count;
  } fcca_out_t;

  typedef struct packed {
    logic     accept;
    logic     scan_init;
    logic     free_init;
    logic     load_out;
    mem_act_t mem;
    status_t  status;
  } fcca_cmd_t;

  typedef struct packed {
    op_t  op;
    logic clr_last;
    logic idx_ok;
    logic scan_hit;
    logic scan_end;
    logic free_stop;
    logic rd_zero;
    logic rd_end;
    logic out_free;
  } fcca_sts_t;

endpackage

// ----- rtl/fcca_dpath.sv -----
// Datapath: allocation table memory, configuration, scan and walk registers, result register.
module fcca_dpath import fcca_pkg::*; #(
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  fcca_cmd_t   cmd,
  output fcca_sts_t   sts,
  input  fcca_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output fcca_out_t   out_data,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  localparam int ADDR_W = $clog2(MAX_CLUSTERS);

  function automatic logic [ADDR_W-1:0] to_addr(input logic [15:0] v);
    to_addr = v[ADDR_W-1:0];
  endfunction

  logic [15:0] mem_q [MAX_CLUSTERS];

  logic [13:0] cc_r;
  logic [12:0] tbl_r;
  logic [12:0] root_r;
  logic [ADDR_W-1:0] clr_r;
  logic        out_valid_r;
  logic        pend_r;
  fcca_out_t   out_data_r;

  logic [2:0]  op_r;
  logic [12:0] idx_r;
  logic [15:0] val_r;
  logic [13:0] ptr_r;
  logic [13:0] chk_r;
  logic [13:0] cnt_r;
  logic [13:0] found_r;
  logic [15:0] cur_r;
  logic [13:0] steps_r;
  logic [15:0] rdata_r;

  logic [13:0] n;
  logic        ptr_lt_n;
  logic        rd_zero;
  logic        scan_hit;
  logic        out_free;
  logic        mem_we;
  logic        mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [15:0] mem_wd;
  status_t     res_st;

  // Saturate the cluster count to the table depth
  assign n        = (32'(cc_r) > MAX_CLUSTERS) ? 14'(MAX_CLUSTERS) : cc_r;
  assign ptr_lt_n = ptr_r < n;
  assign rd_zero  = rdata_r == FREE_MARK;
  assign scan_hit = pend_r && rd_zero && (chk_r != {1'b0, tbl_r}) && (chk_r != {1'b0, root_r});
  assign out_free = !out_valid_r || !out_stall;
  assign res_st   = cmd.status;

  always_comb begin
    sts.op        = op_t'(op_r);
    sts.clr_last  = clr_r == ADDR_W'(MAX_CLUSTERS - 1);
    sts.idx_ok    = {1'b0, idx_r} < n;
    sts.scan_hit  = scan_hit;
    sts.scan_end  = !pend_r && !ptr_lt_n;
    sts.free_stop = (steps_r >= n) || (cur_r >= {2'b00, n});
    sts.rd_zero   = rd_zero;
    sts.rd_end    = rdata_r == END_MARK;
    sts.out_free  = out_free;
  end

  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = '0;
    mem_wd   = FREE_MARK;
    unique case (cmd.mem)
      MEM_IDLE: ;
      MEM_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_r;
      end
      MEM_SCAN: begin
        mem_re   = ptr_lt_n;
        mem_addr = to_addr({2'b00, ptr_r});
      end
      MEM_RD_IDX: begin
        mem_re   = 1'b1;
        mem_addr = to_addr({3'b000, idx_r});
      end
      MEM_WR_IDX_VAL: begin
        mem_we   = 1'b1;
        mem_addr = to_addr({3'b000, idx_r});
        mem_wd   = val_r;
      end
      MEM_WR_IDX_FOUND: begin
        mem_we   = 1'b1;
        mem_addr = to_addr({3'b000, idx_r});
        mem_wd   = {2'b00, found_r};
      end
      MEM_WR_FOUND_END: begin
        mem_we   = 1'b1;
        mem_addr = to_addr({2'b00, found_r});
        mem_wd   = END_MARK;
      end
      MEM_RD_CUR: begin
        mem_re   = 1'b1;
        mem_addr = to_addr(cur_r);
      end
      MEM_WR_CUR_ZERO: begin
        mem_we   = 1'b1;
        mem_addr = to_addr(cur_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem_q[mem_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r        <= CLUSTER_COUNT_RST;
      tbl_r       <= TABLE_CLUSTER_RST;
      root_r      <= ROOT_CLUSTER_RST;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_CLUSTER_COUNT: cc_r   <= cfg_data;
          CFG_TABLE_CLUSTER: tbl_r  <= cfg_data[12:0];
          CFG_ROOT_CLUSTER:  root_r <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (cmd.mem == MEM_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.scan_init) begin
        pend_r <= 1'b0;
      end else if (cmd.mem == MEM_SCAN) begin
        pend_r <= ptr_lt_n;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_data.op;
      idx_r <= in_data.index;
      val_r <= in_data.value;
    end
    if (cmd.scan_init) begin
      ptr_r <= (op_t'(op_r) == OP_COUNT) ? 14'd0 : 14'd1;
      cnt_r <= '0;
    end else if (cmd.mem == MEM_SCAN) begin
      if (ptr_lt_n) begin
        ptr_r <= ptr_r + 14'd1;
        chk_r <= ptr_r;
      end
      if (pend_r && rd_zero) begin
        cnt_r <= cnt_r + 14'd1;
      end
      if (scan_hit) begin
        found_r <= chk_r;
      end
    end
    if (cmd.free_init) begin
      cur_r   <= {3'b000, idx_r};
      steps_r <= '0;
    end else if (cmd.mem == MEM_RD_CUR) begin
      steps_r <= steps_r + 14'd1;
    end else if (cmd.mem == MEM_WR_CUR_ZERO) begin
      cur_r <= rdata_r;
    end
    if (cmd.load_out) begin
      out_data_r.status     <= res_st;
      out_data_r.cluster    <= (res_st == ST_OK &&
                                (op_t'(op_r) == OP_ALLOC || op_t'(op_r) == OP_EXTEND))
                               ? found_r[12:0] : 13'd0;
      out_data_r.entry      <= (res_st == ST_OK && op_t'(op_r) == OP_READ) ? rdata_r : 16'd0;
      out_data_r.free_count <= (op_t'(op_r) == OP_COUNT) ? cnt_r : 14'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/fcca_ctrl.sv -----
// Controller: sequences clearing, scans, chain walks and result hand-off.
module fcca_ctrl import fcca_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  fcca_sts_t sts,
  output fcca_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_EXT_LINK,
    S_ALLOC_MARK,
    S_FREE_RD,
    S_FREE_CHK,
    S_READ_WAIT,
    S_FINISH
  } state_t;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;

  always_comb begin
    state_nxt     = state_r;
    st_nxt        = st_r;
    cmd.accept    = 1'b0;
    cmd.scan_init = 1'b0;
    cmd.free_init = 1'b0;
    cmd.load_out  = 1'b0;
    cmd.mem       = MEM_IDLE;
    cmd.status    = st_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.mem = MEM_CLEAR;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          st_nxt     = ST_OK;
          state_nxt  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.op)
          OP_ALLOC, OP_COUNT: begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end
          OP_EXTEND: begin
            if (sts.idx_ok) begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_SCAN;
            end else begin
              st_nxt    = ST_RANGE;
              state_nxt = S_FINISH;
            end
          end
          OP_FREE: begin
            if (sts.idx_ok) begin
              cmd.free_init = 1'b1;
              state_nxt     = S_FREE_RD;
            end else begin
              st_nxt    = ST_RANGE;
              state_nxt = S_FINISH;
            end
          end
          OP_READ: begin
            if (sts.idx_ok) begin
              cmd.mem   = MEM_RD_IDX;
              state_nxt = S_READ_WAIT;
            end else begin
              st_nxt    = ST_RANGE;
              state_nxt = S_FINISH;
            end
          end
          OP_WRITE: begin
            if (sts.idx_ok) begin
              cmd.mem = MEM_WR_IDX_VAL;
            end else begin
              st_nxt = ST_RANGE;
            end
            state_nxt = S_FINISH;
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_SCAN: begin
        cmd.mem = MEM_SCAN;
        if (sts.op == OP_COUNT) begin
          if (sts.scan_end) begin
            state_nxt = S_FINISH;
          end
        end else if (sts.scan_hit) begin
          state_nxt = (sts.op == OP_EXTEND) ? S_EXT_LINK : S_ALLOC_MARK;
        end else if (sts.scan_end) begin
          st_nxt    = ST_FULL;
          state_nxt = S_FINISH;
        end
      end
      S_EXT_LINK: begin
        cmd.mem   = MEM_WR_IDX_FOUND;
        state_nxt = S_ALLOC_MARK;
      end
      S_ALLOC_MARK: begin
        cmd.mem   = MEM_WR_FOUND_END;
        state_nxt = S_FINISH;
      end
      S_FREE_RD: begin
        if (sts.free_stop) begin
          st_nxt    = ST_BROKEN;
          state_nxt = S_FINISH;
        end else begin
          cmd.mem   = MEM_RD_CUR;
          state_nxt = S_FREE_CHK;
        end
      end
      S_FREE_CHK: begin
        if (sts.rd_zero) begin
          st_nxt    = ST_BROKEN;
          state_nxt = S_FINISH;
        end else begin
          cmd.mem   = MEM_WR_CUR_ZERO;
          state_nxt = sts.rd_end ? S_FINISH : S_FREE_RD;
        end
      end
      S_READ_WAIT: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

endmodule

// ----- rtl/fat_cluster_chain_allocator_unit.sv -----
// Top level of the FAT16-style cluster chain allocator.
// The unit keeps a file allocation table of MAX_CLUSTERS 16-bit entries in a
// single-port memory (0 = free, 0xFFFF = chain end) and serves one command
// item at a time: allocate, extend chain, free chain, read entry, write entry
// and count free. Every item gives exactly one result item. After reset the
// unit sweeps the table to zero, one entry a cycle, with in_stall high until
// the sweep is done; configuration writes are taken throughout, and cfg_ready
// is always high. Allocate and extend scan the table, one entry a cycle, for
// the first free cluster from cluster 1 below the saturated cluster count n,
// skipping the table and root clusters; extend then links the index entry to
// it, and both mark the found cluster as chain end; a full table gives
// ST_FULL. Count scans all n entries from cluster 0. Free walks the chain from
// the index, clearing each entry until the chain end, and stops with
// ST_BROKEN on a free entry, on a link out of range or on the step limit. A
// result waits in its own output register, so the next item is taken while
// the previous result is still stalled; the unit only holds at the end of an
// item when that register is still full and out_stall is high. Configuration
// is to be written only while no item is in flight.
module fat_cluster_chain_allocator_unit import fcca_pkg::*; #(
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  fcca_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output fcca_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  fcca_cmd_t cmd;
  fcca_sts_t sts;

  // Registers accept a write in any cycle
  assign cfg_ready = 1'b1;

  fcca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fcca_dpath #(
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
